### design/dtq_pkg.sv
// Shared types and codes for the delta-list timer queue
package dtq_pkg;

	// Most release words one command may produce
	localparam int MAX_RESULTS = 16;
	localparam int REL_CNT_W   = $clog2(MAX_RESULTS);

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_TICK    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_INSERTED = 2'd0,
		KIND_FULL     = 2'd1,
		KIND_RELEASED = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef struct packed {
		op_t         opcode;
		logic [7:0]  thread_id;
		logic [31:0] delay_ticks;
	} cmd_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] woken_id;
		logic       last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_POP,
		ST_INS_CHK,
		ST_INS_NEW,
		ST_INS_PREV,
		ST_REL_CHK,
		ST_REL_FIN
	} state_t;

endpackage

### design/delta_timer_queue.sv
// Delta-list timer queue.
// Command channel: a word on cmd is taken at a rising edge with start high and
// busy low. opcode selects insert (thread_id, delay_ticks), tick-then-release
// or release. Result channel: each result word sits on res for one cycle with
// done high; the receiver must take it, there is no back-pressure.
// Insert and full reject give one word; a release gives one word per expired
// thread (up to 16, last marked) or a single "nothing released" word.
// Timing: full reject, empty release and the unused opcode answer in the cycle
// after the command. Insert walks the list one entry read per cycle through
// the single read port of the entry RAM. Release of a non-empty list steps
// through the expired head entries and stops at the first unexpired one.
// busy stays high until the final word of the command is on res; the next
// command may be given in the cycle of that word.
// Reset clears the list (empty, all slots free); RAM contents are left as
// they are, since only entries reached through the list are ever read. Fresh
// slots are handed out by a fill count; freed slots go on a free list and are
// reused first.
module delta_timer_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  dtq_pkg::cmd_t  cmd,
	output logic           done,
	output dtq_pkg::res_t  res
);

	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
	localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(QUEUE_DEPTH);

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [31:0]        delta;
		logic [SLOT_W-1:0]  link;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	dtq_pkg::state_t state_q, state_d;

	logic [SLOT_W-1:0]  head_q, head_d;
	logic [OCC_W-1:0]   occ_q, occ_d;
	logic [OCC_W-1:0]   fresh_q, fresh_d;
	logic [SLOT_W-1:0]  fhead_q, fhead_d;
	logic               have_prev_q, have_prev_d;
	logic               tick_q, tick_d;
	logic               pend_valid_q, pend_valid_d;
	logic [dtq_pkg::REL_CNT_W-1:0] rcnt_q, rcnt_d;
	logic               done_q, done_d;
	dtq_pkg::res_t      res_q, res_d;

	logic [SLOT_W-1:0]  slot_q, slot_d;
	logic [SLOT_W-1:0]  cur_q, cur_d;
	logic [SLOT_W-1:0]  prev_q, prev_d;
	logic [SLOT_W-1:0]  link_new_q, link_new_d;
	logic [OCC_W-1:0]   idx_q, idx_d;
	logic [31:0]        d_q, d_d;
	logic [ID_BITS-1:0] id_q, id_d;
	logic [ID_BITS-1:0] pend_id_q, pend_id_d;
	entry_t             prev_word_q, prev_word_d;

	logic               mem_we;
	logic [SLOT_W-1:0]  mem_waddr;
	logic [SLOT_W-1:0]  mem_raddr;
	entry_t             mem_wdata;
	logic [ENTRY_W-1:0] mem_rdata;
	entry_t             rd;
	entry_t             rel_word;
	logic [OCC_W-1:0]   idx_inc;

	function automatic dtq_pkg::res_t mk_res(dtq_pkg::kind_t k, logic [ID_BITS-1:0] id,
			logic lst);
		dtq_pkg::res_t r;
		r.kind     = k;
		r.woken_id = 8'(id);
		r.last     = lst;
		return r;
	endfunction

	dtq_ram #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(ENTRY_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rd      = entry_t'(mem_rdata);
	assign idx_inc = idx_q + 1'b1;

	// head word as seen by a release step: tick decrement applied on the first step
	always_comb begin
		rel_word = rd;
		if (tick_q && rd.delta != 32'd0) begin
			rel_word.delta = rd.delta - 32'd1;
		end
	end

	// next state, RAM access and result word
	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		occ_d        = occ_q;
		fresh_d      = fresh_q;
		fhead_d      = fhead_q;
		have_prev_d  = have_prev_q;
		tick_d       = tick_q;
		pend_valid_d = pend_valid_q;
		rcnt_d       = rcnt_q;
		slot_d       = slot_q;
		cur_d        = cur_q;
		prev_d       = prev_q;
		link_new_d   = link_new_q;
		idx_d        = idx_q;
		d_d          = d_q;
		id_d         = id_q;
		pend_id_d    = pend_id_q;
		prev_word_d  = prev_word_q;
		done_d       = 1'b0;
		res_d        = res_q;
		mem_we       = 1'b0;
		mem_waddr    = '0;
		mem_wdata    = '0;
		mem_raddr    = '0;

		unique case (state_q)
			dtq_pkg::ST_IDLE: begin
				if (start) begin
					unique case (cmd.opcode)
						dtq_pkg::OP_INSERT: begin
							if (occ_q == DEPTH_OCC) begin
								done_d = 1'b1;
								res_d  = mk_res(dtq_pkg::KIND_FULL, '0, 1'b1);
							end else begin
								id_d        = ID_BITS'(cmd.thread_id);
								d_d         = cmd.delay_ticks;
								have_prev_d = 1'b0;
								link_new_d  = '0;
								idx_d       = '0;
								cur_d       = head_q;
								// reuse a freed slot first, else take a fresh one
								if (occ_q < fresh_q) begin
									slot_d    = fhead_q;
									mem_raddr = fhead_q;
									state_d   = dtq_pkg::ST_INS_POP;
								end else begin
									slot_d  = SLOT_W'(fresh_q);
									fresh_d = fresh_q + 1'b1;
									if (occ_q == '0) begin
										state_d = dtq_pkg::ST_INS_NEW;
									end else begin
										mem_raddr = head_q;
										state_d   = dtq_pkg::ST_INS_CHK;
									end
								end
							end
						end
						dtq_pkg::OP_TICK, dtq_pkg::OP_RELEASE: begin
							if (occ_q == '0) begin
								done_d = 1'b1;
								res_d  = mk_res(dtq_pkg::KIND_NONE, '0, 1'b1);
							end else begin
								mem_raddr    = head_q;
								tick_d       = (cmd.opcode == dtq_pkg::OP_TICK);
								pend_valid_d = 1'b0;
								rcnt_d       = '0;
								state_d      = dtq_pkg::ST_REL_CHK;
							end
						end
						dtq_pkg::OP_UNUSED: begin
							done_d = 1'b1;
							res_d  = mk_res(dtq_pkg::KIND_NONE, '0, 1'b1);
						end
					endcase
				end
			end

			// free list pop: the freed slot's link names the next free slot
			dtq_pkg::ST_INS_POP: begin
				fhead_d = rd.link;
				if (occ_q == '0) begin
					state_d = dtq_pkg::ST_INS_NEW;
				end else begin
					mem_raddr = head_q;
					state_d   = dtq_pkg::ST_INS_CHK;
				end
			end

			// walk: stop before the first strictly larger delta
			dtq_pkg::ST_INS_CHK: begin
				if (rd.delta > d_q) begin
					mem_we          = 1'b1;
					mem_waddr       = cur_q;
					mem_wdata       = rd;
					mem_wdata.delta = rd.delta - d_q;
					link_new_d      = cur_q;
					state_d         = dtq_pkg::ST_INS_NEW;
				end else begin
					d_d         = d_q - rd.delta;
					prev_d      = cur_q;
					prev_word_d = rd;
					have_prev_d = 1'b1;
					idx_d       = idx_inc;
					if (idx_inc == occ_q) begin
						link_new_d = '0;
						state_d    = dtq_pkg::ST_INS_NEW;
					end else begin
						cur_d     = rd.link;
						mem_raddr = rd.link;
					end
				end
			end

			// write the new entry
			dtq_pkg::ST_INS_NEW: begin
				mem_we         = 1'b1;
				mem_waddr      = slot_q;
				mem_wdata.id    = id_q;
				mem_wdata.delta = d_q;
				mem_wdata.link  = link_new_q;
				if (have_prev_q) begin
					state_d = dtq_pkg::ST_INS_PREV;
				end else begin
					head_d  = slot_q;
					occ_d   = occ_q + 1'b1;
					done_d  = 1'b1;
					res_d   = mk_res(dtq_pkg::KIND_INSERTED, '0, 1'b1);
					state_d = dtq_pkg::ST_IDLE;
				end
			end

			// relink the predecessor
			dtq_pkg::ST_INS_PREV: begin
				mem_we         = 1'b1;
				mem_waddr      = prev_q;
				mem_wdata      = prev_word_q;
				mem_wdata.link = slot_q;
				occ_d          = occ_q + 1'b1;
				done_d         = 1'b1;
				res_d          = mk_res(dtq_pkg::KIND_INSERTED, '0, 1'b1);
				state_d        = dtq_pkg::ST_IDLE;
			end

			// release step: one head entry per cycle, each word held as pending so the final one can be marked last
			dtq_pkg::ST_REL_CHK: begin
				tick_d    = 1'b0;
				mem_we    = 1'b1;
				mem_waddr = head_q;
				mem_wdata = rel_word;
				if (rel_word.delta != 32'd0) begin
					done_d  = 1'b1;
					res_d   = pend_valid_q ?
						mk_res(dtq_pkg::KIND_RELEASED, pend_id_q, 1'b1) :
						mk_res(dtq_pkg::KIND_NONE, '0, 1'b1);
					pend_valid_d = 1'b0;
					state_d = dtq_pkg::ST_IDLE;
				end else begin
					// expired: push slot on the free list
					mem_wdata.link = fhead_q;
					fhead_d        = head_q;
					if (pend_valid_q) begin
						done_d = 1'b1;
						res_d  = mk_res(dtq_pkg::KIND_RELEASED, pend_id_q, 1'b0);
					end
					pend_valid_d = 1'b1;
					pend_id_d    = rel_word.id;
					occ_d        = occ_q - 1'b1;
					head_d       = rel_word.link;
					rcnt_d       = rcnt_q + 1'b1;
					if (occ_q == OCC_W'(1) ||
							rcnt_q == dtq_pkg::REL_CNT_W'(dtq_pkg::MAX_RESULTS - 1)) begin
						state_d = dtq_pkg::ST_REL_FIN;
					end else begin
						mem_raddr = rel_word.link;
					end
				end
			end

			dtq_pkg::ST_REL_FIN: begin
				done_d       = 1'b1;
				res_d        = mk_res(dtq_pkg::KIND_RELEASED, pend_id_q, 1'b1);
				pend_valid_d = 1'b0;
				state_d      = dtq_pkg::ST_IDLE;
			end

			default: begin
				state_d = dtq_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dtq_pkg::ST_IDLE;
			head_q       <= '0;
			occ_q        <= '0;
			fresh_q      <= '0;
			have_prev_q  <= 1'b0;
			tick_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			rcnt_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			occ_q        <= occ_d;
			fresh_q      <= fresh_d;
			have_prev_q  <= have_prev_d;
			tick_q       <= tick_d;
			pend_valid_q <= pend_valid_d;
			rcnt_q       <= rcnt_d;
			done_q       <= done_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		fhead_q     <= fhead_d;
		slot_q      <= slot_d;
		cur_q       <= cur_d;
		prev_q      <= prev_d;
		link_new_q  <= link_new_d;
		idx_q       <= idx_d;
		d_q         <= d_d;
		id_q        <= id_d;
		pend_id_q   <= pend_id_d;
		prev_word_q <= prev_word_d;
		res_q       <= res_d;
	end

	assign busy = (state_q != dtq_pkg::ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

### design/dtq_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle
module dtq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 44
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### design/dtq_checker.sv
// Port-level checks for the timer queue
module dtq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input dtq_pkg::cmd_t cmd,
	input logic          done,
	input dtq_pkg::res_t res
);

	// only release words may be followed by more words of the same command
	a_nonlast_is_release: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.last |-> res.kind == dtq_pkg::KIND_RELEASED)
		else $error("non-final result word is not a release");

	// id field is zero unless a thread is released
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.kind != dtq_pkg::KIND_RELEASED |-> res.woken_id == 8'd0)
		else $error("woken_id set on a non-release word");

	// an accepted command either answers at once or holds busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || (done && res.last))
		else $error("command accepted without busy or answer");

	// the final word closes the command
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.last |-> !busy)
		else $error("busy still high with the final word");

	// the unused opcode answers next cycle with a single "nothing released" word
	a_unused_op: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.opcode == dtq_pkg::OP_UNUSED |=>
			done && res.last && res.kind == dtq_pkg::KIND_NONE)
		else $error("unused opcode not answered with a single empty word");

endmodule

bind delta_timer_queue dtq_checker u_dtq_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.cmd   (cmd),
	.done  (done),
	.res   (res)
);
